// File: sv/hgpu_pkg.sv
// shared types, constants and helpers for the gray/phase unwrapper
package hgpu_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int FRAC_BITS   = 16;
	localparam int GRAY_W      = 8;
	localparam int OUT_W       = GRAY_W + FRAC_BITS;

	// formula operands before scaling: differences of up to four samples
	localparam int SMALL_W = SAMPLE_BITS + 2;
	// scale of the unit vector components (2^30)
	localparam int ONE_SHIFT = 30;
	// datapath width: scaled operand plus cordic gain and headroom
	localparam int CW = SMALL_W + 34;
	localparam int ACC_W = 32;
	localparam int ITERS = 28;

	// front end: select, scale, pre-rotate; then one stage per iteration; then output
	localparam int FRONT_STAGES = 3;
	localparam int LATENCY = FRONT_STAGES + ITERS + 1;

	localparam logic [2:0] STEPS_3 = 3'd3;
	localparam logic [2:0] STEPS_4 = 3'd4;
	localparam logic [2:0] STEPS_5 = 3'd5;
	localparam logic [2:0] STEPS_RESET = STEPS_4;

	// sqrt(3) in Q2.30
	localparam logic signed [31:0] SQRT3_Q30 = 32'sd1859775393;

	localparam logic [ACC_W-1:0] HALF_TURN = ACC_W'(1) << (ACC_W - 1);
	localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (ACC_W - 1 - FRAC_BITS);

	// atan(2^-i) in turns, 2^32 = one turn
	localparam logic [ACC_W-1:0] ATAN_TURNS [ITERS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81,
		32'd41,        32'd20,        32'd10,        32'd5
	};

	typedef struct packed {
		logic              pix_valid;
		logic              angle_ok;
		logic [GRAY_W-1:0] idx;
	} hgpu_side_t;

	function automatic logic [GRAY_W-1:0] gray_to_bin(input logic [GRAY_W-1:0] g);
		logic [GRAY_W-1:0] b;
		b[GRAY_W-1] = g[GRAY_W-1];
		for (int i = GRAY_W - 2; i >= 0; i--) begin
			b[i] = b[i+1] ^ g[i];
		end
		return b;
	endfunction

endpackage

// File: sv/hgpu_front.sv
// front end: formula select, vector scaling and half-plane pre-rotation
module hgpu_front import hgpu_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic [2:0]              phase_steps,
	input  logic [GRAY_W-1:0]       gray_bits,
	input  logic                    in_mask,
	input  logic [SAMPLE_BITS-1:0]  sample_one,
	input  logic [SAMPLE_BITS-1:0]  sample_two,
	input  logic [SAMPLE_BITS-1:0]  sample_three,
	input  logic [SAMPLE_BITS-1:0]  sample_four,
	input  logic [SAMPLE_BITS-1:0]  sample_five,
	output logic                    out_valid,
	output logic signed [CW-1:0]    x_out,
	output logic signed [CW-1:0]    y_out,
	output logic [ACC_W-1:0]        acc_out,
	output hgpu_side_t              side_out
);

	logic signed [SMALL_W-1:0] s1e, s2e, s3e, s4e, s5e;
	logic signed [SMALL_W-1:0] xsm, ysm;
	logic                      have, is3;
	hgpu_side_t                side_in;

	logic                      v_s1;
	hgpu_side_t                side_s1;
	logic signed [SMALL_W-1:0] xsm_s1, ysm_s1;
	logic                      is3_s1;

	logic signed [SMALL_W+31:0] prod3;
	logic signed [CW-1:0]       x_sc, y_sc;
	hgpu_side_t                 side_nz;

	logic                       v_s2;
	hgpu_side_t                 side_s2;
	logic signed [CW-1:0]       x_s2, y_s2;

	logic                       v_s3;
	hgpu_side_t                 side_s3;
	logic signed [CW-1:0]       x_s3, y_s3;
	logic [ACC_W-1:0]           acc_s3;

	assign s1e = SMALL_W'(sample_one);
	assign s2e = SMALL_W'(sample_two);
	assign s3e = SMALL_W'(sample_three);
	assign s4e = SMALL_W'(sample_four);
	assign s5e = SMALL_W'(sample_five);

	always_comb begin
		xsm  = '0;
		ysm  = '0;
		have = 1'b1;
		is3  = 1'b0;
		case (phase_steps)
			STEPS_3: begin
				ysm = s1e - s3e;
				xsm = (s2e <<< 1) - s1e - s3e;
				is3 = 1'b1;
			end
			STEPS_4: begin
				ysm = s4e - s2e;
				xsm = s1e - s3e;
			end
			STEPS_5: begin
				ysm = (s2e - s4e) <<< 1;
				xsm = (s3e <<< 1) - s1e - s5e;
			end
			default: begin
				have = 1'b0;
			end
		endcase
	end

	// a masked pixel decodes to all zeros
	always_comb begin
		side_in.pix_valid = in_mask;
		side_in.angle_ok  = have & in_mask;
		side_in.idx       = in_mask ? gray_to_bin(gray_bits) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		side_s1 <= side_in;
		xsm_s1  <= xsm;
		ysm_s1  <= ysm;
		is3_s1  <= is3;
	end

	assign prod3 = ysm_s1 * SQRT3_Q30;
	assign x_sc  = {{(CW-SMALL_W-ONE_SHIFT){xsm_s1[SMALL_W-1]}}, xsm_s1, {ONE_SHIFT{1'b0}}};
	assign y_sc  = is3_s1 ? CW'(prod3)
	                      : {{(CW-SMALL_W-ONE_SHIFT){ysm_s1[SMALL_W-1]}}, ysm_s1,
	                         {ONE_SHIFT{1'b0}}};

	// zero vector gives phase 0
	always_comb begin
		side_nz          = side_s1;
		side_nz.angle_ok = side_s1.angle_ok & ((xsm_s1 != '0) | (ysm_s1 != '0));
	end

	always_ff @(posedge clk) begin
		side_s2 <= side_nz;
		x_s2    <= x_sc;
		y_s2    <= y_sc;
	end

	// left half plane: rotate by half a turn first
	always_ff @(posedge clk) begin
		side_s3 <= side_s2;
		if (x_s2[CW-1]) begin
			x_s3   <= -x_s2;
			y_s3   <= -y_s2;
			acc_s3 <= HALF_TURN;
		end else begin
			x_s3   <= x_s2;
			y_s3   <= y_s2;
			acc_s3 <= '0;
		end
	end

	assign out_valid = v_s3;
	assign x_out     = x_s3;
	assign y_out     = y_s3;
	assign acc_out   = acc_s3;
	assign side_out  = side_s3;

`ifndef SYNTHESIS
	a_prerot_right: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && x_s2 != {1'b1, {(CW-1){1'b0}}} |=> !x_s3[CW-1])
		else $error("pre-rotated vector not in right half plane");
	a_mask_zero_idx: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !side_s1.pix_valid |-> side_s1.idx == '0 && !side_s1.angle_ok)
		else $error("masked pixel carries stripe or angle");
	a_bad_steps: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && phase_steps != STEPS_3 && phase_steps != STEPS_4 &&
		phase_steps != STEPS_5 |=> !side_s1.angle_ok)
		else $error("unsupported step count marked as decodable");
`endif

endmodule

// File: sv/hgpu_cordic.sv
// vectoring cordic, one iteration per pipeline stage
module hgpu_cordic import hgpu_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic signed [CW-1:0] x_in,
	input  logic signed [CW-1:0] y_in,
	input  logic [ACC_W-1:0]     acc_in,
	input  hgpu_side_t           side_in,
	output logic                 out_valid,
	output logic [ACC_W-1:0]     acc_out,
	output hgpu_side_t           side_out
);

	logic                 v_s    [ITERS];
	logic signed [CW-1:0] x_s    [ITERS];
	logic signed [CW-1:0] y_s    [ITERS];
	logic [ACC_W-1:0]     acc_s  [ITERS];
	hgpu_side_t           side_s [ITERS];

	for (genvar i = 0; i < ITERS; i++) begin : g_iter
		logic                 vin;
		logic signed [CW-1:0] xin, yin, xsh, ysh;
		logic [ACC_W-1:0]     ain;
		hgpu_side_t           sin;

		if (i == 0) begin : g_first
			assign vin = in_valid;
			assign xin = x_in;
			assign yin = y_in;
			assign ain = acc_in;
			assign sin = side_in;
		end else begin : g_next
			assign vin = v_s[i-1];
			assign xin = x_s[i-1];
			assign yin = y_s[i-1];
			assign ain = acc_s[i-1];
			assign sin = side_s[i-1];
		end

		assign xsh = xin >>> i;
		assign ysh = yin >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else begin
				v_s[i] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			side_s[i] <= sin;
			if (!yin[CW-1]) begin
				x_s[i]   <= xin + ysh;
				y_s[i]   <= yin - xsh;
				acc_s[i] <= ain + ATAN_TURNS[i];
			end else begin
				x_s[i]   <= xin - ysh;
				y_s[i]   <= yin + xsh;
				acc_s[i] <= ain - ATAN_TURNS[i];
			end
		end
	end

	assign out_valid = v_s[ITERS-1];
	assign acc_out   = acc_s[ITERS-1];
	assign side_out  = side_s[ITERS-1];

`ifndef SYNTHESIS
	a_first_x_pos: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[0] && side_s[0].angle_ok |-> !x_s[0][CW-1])
		else $error("cordic x went negative after first iteration");
	a_side_travel: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[ITERS-1] |-> side_s[ITERS-1].pix_valid || !side_s[ITERS-1].angle_ok)
		else $error("masked pixel reached cordic output with an angle");
	a_valid_shift: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |=> v_s[0])
		else $error("cordic dropped a transaction");
`endif

endmodule

// File: sv/hybrid_gray_phase_unwrapper_top.sv
// top level: config register, front end, cordic pipeline and result register
//
//   channel   direction  handshake             payload
//   pixel in  in         start / busy          gray_bits, in_mask, sample_one..sample_five
//   result    out        done (one cycle)      stripe_index, wrapped_phase,
//                                              unwrapped_phase, pixel_valid
//   config    in         cfg_we                cfg_wdata (phase_steps)
//
// one pixel per clock; each result passes through the front end and the cordic
// pipeline (3 front-end stages, 28 cordic iteration stages, 1 output register).
// busy is always low: the pipeline never stalls and the receiver cannot stall.
// reset clears all valid bits and sets phase_steps to 4.
module hybrid_gray_phase_unwrapper_top import hgpu_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	output logic                   done,
	input  logic                   cfg_we,
	input  logic [2:0]             cfg_wdata,
	input  logic [GRAY_W-1:0]      gray_bits,
	input  logic                   in_mask,
	input  logic [SAMPLE_BITS-1:0] sample_one,
	input  logic [SAMPLE_BITS-1:0] sample_two,
	input  logic [SAMPLE_BITS-1:0] sample_three,
	input  logic [SAMPLE_BITS-1:0] sample_four,
	input  logic [SAMPLE_BITS-1:0] sample_five,
	output logic [GRAY_W-1:0]      stripe_index,
	output logic [FRAC_BITS-1:0]   wrapped_phase,
	output logic [OUT_W-1:0]       unwrapped_phase,
	output logic                   pixel_valid
);

	logic [2:0]           phase_steps_q;

	logic                 f_valid;
	logic signed [CW-1:0] f_x, f_y;
	logic [ACC_W-1:0]     f_acc;
	hgpu_side_t           f_side;

	logic                 c_valid;
	logic [ACC_W-1:0]     c_acc;
	hgpu_side_t           c_side;

	logic [ACC_W-1:0]     rnd;
	logic [FRAC_BITS-1:0] wrapped;

	logic                 done_q;
	logic [GRAY_W-1:0]    stripe_q;
	logic [FRAC_BITS-1:0] wrapped_q;
	logic                 pixel_valid_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_steps_q <= STEPS_RESET;
		end else if (cfg_we) begin
			phase_steps_q <= cfg_wdata;
		end
	end

	hgpu_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (start & ~busy),
		.phase_steps  (phase_steps_q),
		.gray_bits    (gray_bits),
		.in_mask      (in_mask),
		.sample_one   (sample_one),
		.sample_two   (sample_two),
		.sample_three (sample_three),
		.sample_four  (sample_four),
		.sample_five  (sample_five),
		.out_valid    (f_valid),
		.x_out        (f_x),
		.y_out        (f_y),
		.acc_out      (f_acc),
		.side_out     (f_side)
	);

	hgpu_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.x_in      (f_x),
		.y_in      (f_y),
		.acc_in    (f_acc),
		.side_in   (f_side),
		.out_valid (c_valid),
		.acc_out   (c_acc),
		.side_out  (c_side)
	);

	// round to nearest; a full turn wraps to zero
	assign rnd     = c_acc + ROUND_BIAS;
	assign wrapped = c_side.angle_ok ? rnd[ACC_W-1 -: FRAC_BITS] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= c_valid;
		end
	end

	always_ff @(posedge clk) begin
		stripe_q      <= c_side.idx;
		wrapped_q     <= wrapped;
		pixel_valid_q <= c_side.pix_valid;
	end

	assign done            = done_q;
	assign stripe_index    = stripe_q;
	assign wrapped_phase   = wrapped_q;
	assign unwrapped_phase = {stripe_q, wrapped_q};
	assign pixel_valid     = pixel_valid_q;

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("result did not arrive at the pipeline latency");
	a_masked_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !pixel_valid |-> stripe_index == '0 && wrapped_phase == '0)
		else $error("masked pixel produced nonzero fields");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(c_valid))
		else $error("result strobe without a transaction");
`endif

endmodule

// File: dv/hybrid_gray_phase_unwrapper_top_tb.sv
// testbench for the hybrid gray-code / phase-shift unwrapper top level
module hybrid_gray_phase_unwrapper_top_tb import hgpu_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [GRAY_W-1:0]               gray;
		logic                            mask;
		logic [4:0][SAMPLE_BITS-1:0]     smp;
	} pixel_t;

	typedef struct {
		logic [GRAY_W-1:0]    stripe;
		logic [FRAC_BITS-1:0] wrapped;
		logic [OUT_W-1:0]     unwrapped;
		logic                 valid;
	} decode_t;

	// atan(2^-i) in turns, 2^32 = one turn
	localparam logic [31:0] ANGLE_STEP [28] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81,
		32'd41,        32'd20,        32'd10,        32'd5
	};
	localparam longint ROOT3_Q30 = 64'sd1859775393;
	localparam longint UNIT_Q30  = 64'sd1 << 30;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic                   busy;
	logic                   done;
	logic                   cfg_we = 1'b0;
	logic [2:0]             cfg_wdata = '0;
	logic [GRAY_W-1:0]      gray_bits = '0;
	logic                   in_mask = 1'b0;
	logic [SAMPLE_BITS-1:0] sample_one = '0;
	logic [SAMPLE_BITS-1:0] sample_two = '0;
	logic [SAMPLE_BITS-1:0] sample_three = '0;
	logic [SAMPLE_BITS-1:0] sample_four = '0;
	logic [SAMPLE_BITS-1:0] sample_five = '0;
	logic [GRAY_W-1:0]      stripe_index;
	logic [FRAC_BITS-1:0]   wrapped_phase;
	logic [OUT_W-1:0]       unwrapped_phase;
	logic                   pixel_valid;

	decode_t    pending_decodes[$];
	logic [2:0] steps_setting = STEPS_RESET;
	int         mismatch_count = 0;

	hybrid_gray_phase_unwrapper_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.done(done),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.gray_bits(gray_bits),
		.in_mask(in_mask),
		.sample_one(sample_one),
		.sample_two(sample_two),
		.sample_three(sample_three),
		.sample_four(sample_four),
		.sample_five(sample_five),
		.stripe_index(stripe_index),
		.wrapped_phase(wrapped_phase),
		.unwrapped_phase(unwrapped_phase),
		.pixel_valid(pixel_valid)
	);

	always #4 clk = ~clk;

	function automatic logic [31:0] vector_turns(input longint x, input longint y);
		logic [31:0] acc;
		longint      xs;
		longint      ys;
		acc = '0;
		if (x < 0) begin
			x = -x;
			y = -y;
			acc = 32'h8000_0000;
		end
		for (int i = 0; i < 28; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys;
				y -= xs;
				acc += ANGLE_STEP[i];
			end else begin
				x -= ys;
				y += xs;
				acc -= ANGLE_STEP[i];
			end
		end
		return acc;
	endfunction

	function automatic decode_t decode_pixel(input pixel_t p);
		decode_t     r;
		longint      s [5];
		longint      x;
		longint      y;
		logic        formula_ok;
		logic [32:0] rounded;
		r = '{default: '0};
		if (!p.mask)
			return r;
		// gray to binary, msb first
		for (int i = GRAY_W - 1; i >= 0; i--) begin
			r.stripe[i] = p.gray[i] ^ ((i == GRAY_W - 1) ? 1'b0 : r.stripe[i+1]);
		end
		for (int k = 0; k < 5; k++) begin
			s[k] = longint'(p.smp[k]);
		end
		formula_ok = 1'b1;
		x = 0;
		y = 0;
		case (steps_setting)
			STEPS_3: begin
				y = (s[0] - s[2]) * ROOT3_Q30;
				x = (2 * s[1] - s[0] - s[2]) * UNIT_Q30;
			end
			STEPS_4: begin
				y = (s[3] - s[1]) * UNIT_Q30;
				x = (s[0] - s[2]) * UNIT_Q30;
			end
			STEPS_5: begin
				y = 2 * (s[1] - s[3]) * UNIT_Q30;
				x = (2 * s[2] - s[0] - s[4]) * UNIT_Q30;
			end
			default: formula_ok = 1'b0;
		endcase
		if (formula_ok && (x != 0 || y != 0)) begin
			rounded = {1'b0, vector_turns(x, y)} + (33'd1 << (31 - FRAC_BITS));
			// a full turn rounds back to zero
			r.wrapped = rounded[31:32-FRAC_BITS];
		end
		r.unwrapped = (OUT_W'(r.stripe) << FRAC_BITS) + OUT_W'(r.wrapped);
		r.valid = 1'b1;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	always @(posedge clk) begin : check_results
		decode_t want;
		if (arst_n && done) begin
			if (pending_decodes.size() == 0) begin
				report_mismatch("result with no transaction outstanding");
			end else begin
				want = pending_decodes.pop_front();
				if (stripe_index !== want.stripe)
					report_mismatch($sformatf("stripe_index %0d, expected %0d",
						stripe_index, want.stripe));
				if (wrapped_phase !== want.wrapped)
					report_mismatch($sformatf("wrapped_phase %0d, expected %0d",
						wrapped_phase, want.wrapped));
				if (unwrapped_phase !== want.unwrapped)
					report_mismatch($sformatf("unwrapped_phase %0d, expected %0d",
						unwrapped_phase, want.unwrapped));
				if (pixel_valid !== want.valid)
					report_mismatch($sformatf("pixel_valid %0b, expected %0b",
						pixel_valid, want.valid));
			end
		end
	end

	function automatic pixel_t make_pixel(input logic [GRAY_W-1:0] g, input logic m,
		input logic [SAMPLE_BITS-1:0] a, input logic [SAMPLE_BITS-1:0] b,
		input logic [SAMPLE_BITS-1:0] c, input logic [SAMPLE_BITS-1:0] d,
		input logic [SAMPLE_BITS-1:0] e);
		pixel_t p;
		p.gray = g;
		p.mask = m;
		p.smp = {e, d, c, b, a};
		return p;
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t p;
		int     kind;
		logic [SAMPLE_BITS-1:0] level;
		p.gray = GRAY_W'($urandom);
		p.mask = ($urandom_range(0, 7) != 0);
		kind = $urandom_range(0, 9);
		level = SAMPLE_BITS'($urandom);
		for (int k = 0; k < 5; k++) begin
			case (kind)
				6: p.smp[k] = SAMPLE_BITS'($urandom_range(0, 31));
				7: p.smp[k] = SAMPLE_BITS'($urandom_range(65504, 65535));
				// all equal gives a zero vector for every formula
				8: p.smp[k] = level;
				// near-zero vector: tiny offsets around one level
				9: p.smp[k] = level ^ SAMPLE_BITS'($urandom_range(0, 3));
				default: p.smp[k] = SAMPLE_BITS'($urandom);
			endcase
		end
		return p;
	endfunction

	task automatic send_pixel(input pixel_t p);
		start <= 1'b1;
		gray_bits <= p.gray;
		in_mask <= p.mask;
		sample_one <= p.smp[0];
		sample_two <= p.smp[1];
		sample_three <= p.smp[2];
		sample_four <= p.smp[3];
		sample_five <= p.smp[4];
		do @(posedge clk); while (busy);
		pending_decodes.push_back(decode_pixel(p));
	endtask

	task automatic write_steps(input logic [2:0] v);
		start <= 1'b0;
		while (pending_decodes.size() != 0) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		steps_setting = v;
	endtask

	task automatic run_random_pixels(input int n, input bit allow_idle);
		for (int i = 0; i < n; i++) begin
			send_pixel(random_pixel());
			if (allow_idle && $urandom_range(0, 3) == 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
		end
	endtask

	task automatic test_directed_cases();
		// reset setting: four steps
		send_pixel(make_pixel(8'hFF, 1'b0, 16'hFFFF, 16'hFFFF, 16'h0, 16'hFFFF, 16'hFFFF));
		send_pixel(make_pixel(8'h00, 1'b1, 16'h1234, 16'h1234, 16'h1234, 16'h1234, 16'h1234));
		send_pixel(make_pixel(8'hFF, 1'b1, 16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0));
		send_pixel(make_pixel(8'h80, 1'b1, 16'h0, 16'h0, 16'hFFFF, 16'h0, 16'h0));
		send_pixel(make_pixel(8'h01, 1'b1, 16'h0, 16'h0, 16'h0, 16'hFFFF, 16'h0));
		send_pixel(make_pixel(8'h55, 1'b1, 16'h0, 16'hFFFF, 16'h0, 16'h0, 16'h0));
		// tiny negative angle rounds up to a full turn, which wraps to zero
		send_pixel(make_pixel(8'hAA, 1'b1, 16'hFFFF, 16'h1, 16'h0, 16'h0, 16'hFFFF));
		send_pixel(make_pixel(8'h7F, 1'b1, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0));
		write_steps(STEPS_3);
		send_pixel(make_pixel(8'hC3, 1'b1, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 16'h1));
		send_pixel(make_pixel(8'h3C, 1'b1, 16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0));
		send_pixel(make_pixel(8'hFF, 1'b1, 16'h0, 16'hFFFF, 16'h0, 16'h0, 16'hFFFF));
		send_pixel(make_pixel(8'h80, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0, 16'h0));
		send_pixel(make_pixel(8'h00, 1'b0, 16'h1, 16'h2, 16'h3, 16'h4, 16'h5));
		write_steps(STEPS_5);
		send_pixel(make_pixel(8'h5A, 1'b1, 16'h4000, 16'h4000, 16'h4000, 16'h4000, 16'h4000));
		send_pixel(make_pixel(8'hA5, 1'b1, 16'h0, 16'hFFFF, 16'h0, 16'h0, 16'h0));
		send_pixel(make_pixel(8'hFF, 1'b1, 16'hFFFF, 16'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_pixel(make_pixel(8'h01, 1'b1, 16'h0, 16'h0, 16'hFFFF, 16'h0, 16'h0));
		write_steps(3'd0);
		send_pixel(make_pixel(8'hFF, 1'b1, 16'hFFFF, 16'h0, 16'h0, 16'hFFFF, 16'h0));
		write_steps(3'd7);
		send_pixel(make_pixel(8'h80, 1'b1, 16'h0, 16'hFFFF, 16'h0, 16'h0, 16'hFFFF));
		send_pixel(make_pixel(8'h80, 1'b0, 16'h0, 16'hFFFF, 16'h0, 16'h0, 16'hFFFF));
	endtask

	task automatic test_three_step_random();
		write_steps(STEPS_3);
		run_random_pixels(400, 1'b1);
	endtask

	task automatic test_four_step_random();
		write_steps(STEPS_4);
		run_random_pixels(400, 1'b1);
	endtask

	task automatic test_five_step_random();
		write_steps(STEPS_5);
		run_random_pixels(400, 1'b1);
	endtask

	task automatic test_unsupported_steps();
		for (int v = 0; v < 8; v++) begin
			if (v != STEPS_3 && v != STEPS_4 && v != STEPS_5) begin
				write_steps(3'(v));
				run_random_pixels(16, 1'b1);
			end
		end
	endtask

	// full-rate streaming, no gaps, across all legal formulas
	task automatic test_back_to_back();
		write_steps(STEPS_4);
		run_random_pixels(70, 1'b0);
		write_steps(STEPS_3);
		run_random_pixels(70, 1'b0);
		write_steps(STEPS_5);
		run_random_pixels(70, 1'b0);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_three_step_random();
		test_four_step_random();
		test_five_step_random();
		test_unsupported_steps();
		test_back_to_back();
		start <= 1'b0;
		while (pending_decodes.size() != 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: files.f
sv/hgpu_pkg.sv
sv/hgpu_front.sv
sv/hgpu_cordic.sv
sv/hybrid_gray_phase_unwrapper_top.sv
dv/hybrid_gray_phase_unwrapper_top_tb.sv
